FILE: rtl/core/rkw_pkg.sv
// ----------------------------------------------------------------------------
// rkw_pkg
// Shared types and constants of the resample kernel weight generator:
// register indexes, filter modes, datapath widths and the control bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rkw_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUBIC_COEFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_SIZE = 2'd3;

  // Register widths
  localparam int unsigned MODE_W = 2;
  localparam int unsigned COEFF_W = 13;
  localparam int unsigned SCALE_W = 14;
  localparam int unsigned BORDER_W = 14;
  localparam int unsigned CFG_DATA_W = 14;

  // Filter modes
  localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRIANGLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BICUBIC = 2'd2;

  // Reset values
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_TRIANGLE;
  localparam logic signed [COEFF_W-1:0] COEFF_RESET = -13'sd2048;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 14'd4096;
  localparam logic [BORDER_W-1:0] BORDER_RESET = 14'd8192;

  // Datapath widths
  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned ACC_W = 24;
  localparam int unsigned MUL_A_W = ACC_W;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned PROD_W = MUL_A_W + MUL_B_W;
  localparam int unsigned T_W = 18;
  localparam int unsigned TAP_CNT_W = 3;
  localparam int unsigned MAX_TAPS = 5;

  localparam logic signed [ACC_W-1:0] ONE_Q14 = 24'sd16384;
  localparam logic signed [ACC_W-1:0] THREE_Q14 = 24'sd49152;
  localparam logic signed [ACC_W-1:0] TWO_Q14 = 24'sd32768;
  localparam logic [T_W-1:0] T_ONE = 18'd16384;
  localparam logic [T_W-1:0] T_TWO = 18'd32768;
  localparam logic signed [PROD_W-1:0] HALF_Q14 = 41'sd8192;
  localparam logic signed [PROD_W-1:0] HALF_Q12 = 41'sd2048;
  localparam logic signed [PROD_W-1:0] WEIGHT_MAX = 41'sd65535;
  localparam logic signed [PROD_W-1:0] WEIGHT_MIN = -41'sd65536;

  // Operations of the shared multiplier
  typedef enum logic [2:0] {
    OP_MAG = 3'd0,
    OP_C1  = 3'd1,
    OP_C2  = 3'd2,
    OP_C3  = 3'd3,
    OP_WGT = 3'd4
  } mul_op_e;

  typedef struct packed {
    logic    load;
    logic    setup;
    logic    check;
    logic    diff;
    logic    mul;
    logic    acc;
    logic    emit;
    logic    next;
    mul_op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
    logic cubic;
    logic out_free;
  } ctrl_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/rkw_ctrl.sv
// ----------------------------------------------------------------------------
// rkw_ctrl
// Sequencer: accepts a request, sets up the window, then walks the taps and
// steps the shared multiplier through the ops each filter mode needs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rkw_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire rkw_pkg::ctrl_status_t status_i,
  output rkw_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SETUP = 7'b0000010,
    ST_CHECK = 7'b0000100,
    ST_DIFF  = 7'b0001000,
    ST_MUL   = 7'b0010000,
    ST_ACC   = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } ctrl_state_e;

  ctrl_state_e      state_q, state_d;
  rkw_pkg::mul_op_e op_q, op_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    cmd_o     = '0;
    cmd_o.op  = op_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = status_i.empty ? ST_EMIT : ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        op_d       = rkw_pkg::OP_MAG;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = ST_MUL;
        case (op_q)
          rkw_pkg::OP_MAG: op_d = status_i.cubic ? rkw_pkg::OP_C1 : rkw_pkg::OP_WGT;
          rkw_pkg::OP_C1:  op_d = rkw_pkg::OP_C2;
          rkw_pkg::OP_C2:  op_d = rkw_pkg::OP_C3;
          rkw_pkg::OP_C3:  op_d = rkw_pkg::OP_WGT;
          default:         state_d = ST_EMIT;
        endcase
      end
      ST_EMIT: begin
        // hold until the output register can take the tap
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.next = 1'b1;
            state_d    = ST_DIFF;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= rkw_pkg::OP_MAG;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rkw_datapath.sv
// ----------------------------------------------------------------------------
// rkw_datapath
// Configuration registers, window bounds, tap distance, the shared signed
// multiplier with its accumulate stage, weight saturation and the output
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rkw_datapath #(
  parameter int unsigned COORD_BITS = 13,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [rkw_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire  [rkw_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  wire  [COORD_BITS+FRAC_BITS-1:0]      sample_center_i,
  input  wire rkw_pkg::ctrl_cmd_t              cmd_i,
  output rkw_pkg::ctrl_status_t                status_o,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic [COORD_BITS-1:0]                tap_position_o,
  output logic signed [rkw_pkg::WEIGHT_W-1:0]  tap_weight_o,
  output logic                                 last_tap_o,
  output logic                                 window_empty_o
);

  localparam int unsigned CW    = COORD_BITS + FRAC_BITS;
  localparam int unsigned XW    = COORD_BITS + 1;
  localparam int unsigned RW    = FRAC_BITS + 2;
  localparam int unsigned AD_W  = FRAC_BITS + 2;
  localparam int unsigned MAG_W = FRAC_BITS + 16;
  localparam int unsigned SH    = FRAC_BITS - 2;
  localparam int unsigned LW    = (rkw_pkg::BORDER_W > XW) ? rkw_pkg::BORDER_W : XW;
  localparam int unsigned ACC_W = rkw_pkg::ACC_W;
  localparam int unsigned PROD_W = rkw_pkg::PROD_W;

  localparam logic [CW:0]      CEIL_ADD = (CW + 1)'((1 << FRAC_BITS) - 1);
  localparam logic [LW-1:0]    LIM_MAX  = LW'(1) << COORD_BITS;
  localparam logic [MAG_W:0]   HALF_SH  = (MAG_W + 1)'(1) << (SH - 1);
  localparam logic [MAG_W-1:0] NEAR_LIM = MAG_W'(1) << (FRAC_BITS + 11);

  // Configuration
  logic [rkw_pkg::MODE_W-1:0]          mode_q;
  logic signed [rkw_pkg::COEFF_W-1:0]  coeff_q;
  logic [rkw_pkg::SCALE_W-1:0]         rk_q;
  logic [rkw_pkg::BORDER_W-1:0]        border_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= rkw_pkg::MODE_RESET;
      coeff_q  <= rkw_pkg::COEFF_RESET;
      rk_q     <= rkw_pkg::SCALE_RESET;
      border_q <= rkw_pkg::BORDER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rkw_pkg::CFG_FILTER_MODE:  mode_q   <= cfg_wdata_i[rkw_pkg::MODE_W-1:0];
        rkw_pkg::CFG_CUBIC_COEFF:  coeff_q  <= cfg_wdata_i[rkw_pkg::COEFF_W-1:0];
        rkw_pkg::CFG_SCALE_FACTOR: rk_q     <= cfg_wdata_i[rkw_pkg::SCALE_W-1:0];
        rkw_pkg::CFG_BORDER_SIZE:  border_q <= cfg_wdata_i[rkw_pkg::BORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // Working registers
  logic [CW-1:0]                     center_q;
  logic [XW-1:0]                     x_q, hi_q;
  logic                              empty_q;
  logic [rkw_pkg::TAP_CNT_W-1:0]     tap_cnt_q;
  logic [AD_W-1:0]                   absd_q;
  logic [rkw_pkg::T_W-1:0]           t_q;
  logic                              near_q;
  logic signed [ACC_W-1:0]           acc_q;
  logic signed [PROD_W-1:0]          prod_q;
  logic signed [rkw_pkg::WEIGHT_W-1:0] weight_q;

  // Window bounds
  logic [RW-1:0]   radius;
  logic [CW:0]     c_minus_r, hi_sum;
  logic [XW-1:0]   lo_val, hi_raw, lim_val, hi_val;
  logic [LW-1:0]   border_ext;

  always_comb begin
    case (mode_q)
      rkw_pkg::MODE_NEAREST:  radius = RW'(1) << (FRAC_BITS - 1);
      rkw_pkg::MODE_TRIANGLE: radius = RW'(1) << FRAC_BITS;
      rkw_pkg::MODE_BICUBIC:  radius = RW'(1) << (FRAC_BITS + 1);
      default:                radius = '0;
    endcase
  end

  assign c_minus_r  = {1'b0, center_q} - (CW + 1)'(radius);
  assign lo_val     = c_minus_r[CW] ? '0 : XW'(c_minus_r[CW-1:FRAC_BITS]);
  assign hi_sum     = {1'b0, center_q} + (CW + 1)'(radius) + CEIL_ADD;
  assign hi_raw     = hi_sum[CW:FRAC_BITS];
  assign border_ext = LW'(border_q);
  assign lim_val    = (border_ext > LIM_MAX) ? XW'(LIM_MAX) : XW'(border_ext);
  assign hi_val     = (hi_raw > lim_val) ? lim_val : hi_raw;

  // Distance from the pixel center to the sample center
  logic [CW-1:0] pix_center;
  logic [CW:0]   dv, dmag;

  assign pix_center = {x_q[COORD_BITS-1:0], 1'b1, {(FRAC_BITS - 1){1'b0}}};
  assign dv         = {1'b0, pix_center} - {1'b0, center_q};
  assign dmag       = dv[CW] ? (~dv + 1'b1) : dv;

  // Shared multiplier operands
  logic signed [ACC_W-1:0]            a14, f_sel;
  logic signed [rkw_pkg::MUL_A_W-1:0] mul_a;
  logic signed [rkw_pkg::MUL_B_W-1:0] mul_b;
  logic                               t_lt1, t_lt2;

  assign a14   = {{(ACC_W - rkw_pkg::COEFF_W - 2){coeff_q[rkw_pkg::COEFF_W-1]}}, coeff_q, 2'b00};
  assign t_lt1 = (t_q < rkw_pkg::T_ONE);
  assign t_lt2 = (t_q < rkw_pkg::T_TWO);

  always_comb begin
    case (mode_q)
      rkw_pkg::MODE_NEAREST:  f_sel = near_q ? rkw_pkg::ONE_Q14 : '0;
      rkw_pkg::MODE_TRIANGLE: f_sel = t_lt1 ? (rkw_pkg::ONE_Q14 - ACC_W'(t_q)) : '0;
      rkw_pkg::MODE_BICUBIC:  f_sel = t_lt2 ? acc_q : '0;
      default:                f_sel = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.op)
      rkw_pkg::OP_MAG: begin
        mul_a = rkw_pkg::MUL_A_W'(absd_q);
        mul_b = rkw_pkg::MUL_B_W'(rk_q);
      end
      rkw_pkg::OP_C1: begin
        mul_a = t_lt1 ? (a14 + rkw_pkg::TWO_Q14) : a14;
        mul_b = rkw_pkg::MUL_B_W'(t_q[15:0]);
      end
      rkw_pkg::OP_C2, rkw_pkg::OP_C3: begin
        mul_a = acc_q;
        mul_b = rkw_pkg::MUL_B_W'(t_q[15:0]);
      end
      default: begin
        mul_a = f_sel;
        mul_b = rkw_pkg::MUL_B_W'(rk_q);
      end
    endcase
  end

  // Round-half-up rescaling of the product
  logic signed [PROD_W-1:0] rnd14, q14, rnd12, q12;
  logic signed [ACC_W-1:0]  q14_n;
  logic [MAG_W-1:0]         mag;
  logic [MAG_W:0]           t_full;

  assign rnd14  = prod_q + rkw_pkg::HALF_Q14;
  assign q14    = rnd14 >>> 14;
  assign q14_n  = q14[ACC_W-1:0];
  assign rnd12  = prod_q + rkw_pkg::HALF_Q12;
  assign q12    = rnd12 >>> 12;
  assign mag    = prod_q[MAG_W-1:0];
  assign t_full = ({1'b0, mag} + HALF_SH) >> SH;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      center_q <= sample_center_i;
    end
    if (cmd_i.setup) begin
      x_q  <= lo_val;
      hi_q <= hi_val;
    end else if (cmd_i.next) begin
      x_q <= x_q + 1'b1;
    end
    if (cmd_i.diff) begin
      absd_q <= dmag[AD_W-1:0];
    end
    if (cmd_i.mul) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.acc) begin
      case (cmd_i.op)
        rkw_pkg::OP_MAG: begin
          t_q    <= t_full[rkw_pkg::T_W-1:0];
          near_q <= (mag <= NEAR_LIM);
        end
        rkw_pkg::OP_C1:
          acc_q <= q14_n - (t_lt1 ? (a14 + rkw_pkg::THREE_Q14) : ((a14 <<< 2) + a14));
        rkw_pkg::OP_C2:
          acc_q <= q14_n + (t_lt1 ? '0 : (a14 <<< 3));
        rkw_pkg::OP_C3:
          acc_q <= q14_n + (t_lt1 ? rkw_pkg::ONE_Q14 : -(a14 <<< 2));
        default: begin
          if (q12 > rkw_pkg::WEIGHT_MAX) begin
            weight_q <= rkw_pkg::WEIGHT_MAX[rkw_pkg::WEIGHT_W-1:0];
          end else if (q12 < rkw_pkg::WEIGHT_MIN) begin
            weight_q <= rkw_pkg::WEIGHT_MIN[rkw_pkg::WEIGHT_W-1:0];
          end else begin
            weight_q <= q12[rkw_pkg::WEIGHT_W-1:0];
          end
        end
      endcase
    end
  end

  // Tap walk control
  logic tap_last;

  assign tap_last = empty_q || ((x_q + 1'b1) == hi_q) ||
                    (tap_cnt_q == rkw_pkg::TAP_CNT_W'(rkw_pkg::MAX_TAPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q   <= 1'b0;
      tap_cnt_q <= '0;
    end else begin
      if (cmd_i.check) begin
        empty_q   <= (x_q >= hi_q);
        tap_cnt_q <= '0;
      end else if (cmd_i.next) begin
        tap_cnt_q <= tap_cnt_q + 1'b1;
      end
    end
  end

  // Output register
  logic out_valid_q;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      tap_position_o <= empty_q ? '0 : x_q[COORD_BITS-1:0];
      tap_weight_o   <= empty_q ? '0 : weight_q;
      last_tap_o     <= tap_last;
      window_empty_o <= empty_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign status_o.empty    = (x_q >= hi_q);
  assign status_o.last     = tap_last;
  assign status_o.cubic    = (mode_q == rkw_pkg::MODE_BICUBIC);
  assign status_o.out_free = out_free;

  // Checks
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_empty_o |-> last_tap_o && (tap_weight_o == '0))
    else $error("empty window result not flagged as last with zero weight");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("tap emitted while output register busy");

  a_tap_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && !empty_q |-> (x_q < hi_q))
    else $error("tap position outside clipped window");

  a_tap_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && !empty_q |-> (tap_cnt_q < rkw_pkg::TAP_CNT_W'(rkw_pkg::MAX_TAPS)))
    else $error("too many taps for one center");

  a_next_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.next |-> !tap_last)
    else $error("advanced past the last tap");

endmodule

`default_nettype wire

FILE: rtl/core/resample_kernel_weights_core.sv
// ----------------------------------------------------------------------------
// resample_kernel_weights_core
// Resampling tap weight generator (nearest, triangle, Keys bicubic).
// ----------------------------------------------------------------------------
// One request carries a sample center; the block answers with one result per
// source pixel in the clipped window (at most five), the final one flagged
// last, or a single result flagged empty. A request is taken only while the
// block is idle, and results leave through an output register, so the next
// request can be taken while the final result still waits. The window is set
// up and checked once per request; an empty window goes straight to the
// result, else each tap passes a distance step, its multiplies and an emit.
// Per tap the time is set by the single shared 24x17 signed multiplier: each
// multiply goes into a product register and is then rounded and accumulated,
// and bicubic needs five multiplies per tap against two.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module resample_kernel_weights_core #(
  parameter int unsigned COORD_BITS = 13,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [rkw_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire  [rkw_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  [COORD_BITS+FRAC_BITS-1:0]      sample_center_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic [COORD_BITS-1:0]                tap_position_o,
  output logic signed [rkw_pkg::WEIGHT_W-1:0]  tap_weight_o,
  output logic                                 last_tap_o,
  output logic                                 window_empty_o
);

  rkw_pkg::ctrl_cmd_t    cmd;
  rkw_pkg::ctrl_status_t status;

  rkw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rkw_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .sample_center_i (sample_center_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .tap_position_o  (tap_position_o),
    .tap_weight_o    (tap_weight_o),
    .last_tap_o      (last_tap_o),
    .window_empty_o  (window_empty_o)
  );

endmodule

`default_nettype wire

FILE: verif/resample_kernel_weights_core_tb.sv
// ----------------------------------------------------------------------------
// resample_kernel_weights_core_tb
// Self-checking bench for the resampling tap weight generator. A built-in
// predictor computes the clipped window and every tap weight for each accepted
// center. The bench checks each result field against it, under random bursts
// on the request side and random stall patterns on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module resample_kernel_weights_core_tb;
  import rkw_pkg::*;

  localparam int COORD_BITS = 13;
  localparam int FRAC_BITS = 8;
  localparam int CENTER_W = COORD_BITS + FRAC_BITS;
  localparam int CLK_HALF = 5;
  localparam int RESET_CYCLES = 10;
  localparam int END_WAIT = 100;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 48;
  localparam int PIXEL = 1 << FRAC_BITS;
  localparam int HALF_PIXEL = 1 << (FRAC_BITS - 1);
  localparam int PIXEL_SPAN = 1 << COORD_BITS;
  localparam longint UNIT_Q14 = 16384;
  localparam longint SAT_HI = 65535;
  localparam longint SAT_LO = -65536;
  localparam logic [MODE_W-1:0] MODE_UNDEFINED = 2'd3;

  typedef struct packed {
    logic [COORD_BITS-1:0]      pos;
    logic signed [WEIGHT_W-1:0] weight;
    logic                       last;
    logic                       empty;
  } tap_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index_i = CFG_FILTER_MODE;
  logic [CFG_DATA_W-1:0]         cfg_wdata_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [CENTER_W-1:0]           sample_center_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [COORD_BITS-1:0]         tap_position_o;
  logic signed [WEIGHT_W-1:0]    tap_weight_o;
  logic                          last_tap_o;
  logic                          window_empty_o;

  // Predictor copy of the registers
  logic [MODE_W-1:0]             cfg_mode = MODE_RESET;
  logic signed [COEFF_W-1:0]     cfg_coeff = COEFF_RESET;
  logic [SCALE_W-1:0]            cfg_scale = SCALE_RESET;
  logic [BORDER_W-1:0]           cfg_border = BORDER_RESET;

  tap_t expected_taps[$];
  tap_t observed_tap;
  int   fail_count = 0;
  int   cycle_count = 0;
  int   burst_left = 0;
  int   gap_max = 0;
  int   stall_mode = 0;
  int   stall_phase_left = 0;
  int   stall_run = 0;

  resample_kernel_weights_core #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_center_i(sample_center_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .tap_position_o (tap_position_o),
    .tap_weight_o   (tap_weight_o),
    .last_tap_o     (last_tap_o),
    .window_empty_o (window_empty_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Q.14 product, rounded half up
  function automatic longint q14_mul(input longint p, input longint q);
    return (p * q + (UNIT_Q14 >>> 1)) >>> 14;
  endfunction

  function automatic longint keys_cubic(input longint t);
    longint a;
    longint p;
    a = longint'(cfg_coeff) * 4;
    if (t < UNIT_Q14) begin
      p = q14_mul(a + 2 * UNIT_Q14, t) - (a + 3 * UNIT_Q14);
      p = q14_mul(p, t);
      p = q14_mul(p, t);
      return p + UNIT_Q14;
    end
    if (t < 2 * UNIT_Q14) begin
      p = q14_mul(a, t) - 5 * a;
      p = q14_mul(p, t) + 8 * a;
      p = q14_mul(p, t);
      return p - 4 * a;
    end
    return 0;
  endfunction

  function automatic void predict_taps(input logic [CENTER_W-1:0] center);
    longint c;
    longint r;
    longint lo;
    longint hi;
    longint lim;
    longint x;
    longint diff;
    longint mag;
    longint t;
    longint f;
    longint w;
    longint sc;
    int     n;
    tap_t   taps[MAX_TAPS];
    c = longint'(center);
    sc = longint'(cfg_scale);
    case (cfg_mode)
      MODE_NEAREST:  r = HALF_PIXEL;
      MODE_TRIANGLE: r = PIXEL;
      MODE_BICUBIC:  r = 2 * PIXEL;
      default:       r = 0;
    endcase
    lo = (c >= r) ? ((c - r) >>> FRAC_BITS) : 0;
    hi = (c + r + PIXEL - 1) >>> FRAC_BITS;
    lim = longint'(cfg_border);
    if (lim > PIXEL_SPAN) lim = PIXEL_SPAN;
    if (hi > lim) hi = lim;
    if (lo >= hi) begin
      expected_taps.push_back('{pos: '0, weight: '0, last: 1'b1, empty: 1'b1});
      return;
    end
    n = 0;
    for (x = lo; x < hi && n < MAX_TAPS; x++) begin
      diff = x * PIXEL + HALF_PIXEL - c;
      mag = (diff < 0 ? -diff : diff) * sc;
      // |d| to Q.14: drop FRAC_BITS-2 fraction bits, round half up
      t = (mag + (longint'(1) << (FRAC_BITS - 3))) >>> (FRAC_BITS - 2);
      case (cfg_mode)
        MODE_NEAREST:
          w = (mag <= (longint'(1) << (FRAC_BITS + 11))) ? sc * 4 : 0;
        MODE_TRIANGLE: begin
          f = (t < UNIT_Q14) ? UNIT_Q14 - t : 0;
          w = (f * sc + 2048) >>> 12;
        end
        MODE_BICUBIC:
          w = (keys_cubic(t) * sc + 2048) >>> 12;
        default:
          w = 0;
      endcase
      if (w > SAT_HI) w = SAT_HI;
      if (w < SAT_LO) w = SAT_LO;
      taps[n].pos = x[COORD_BITS-1:0];
      taps[n].weight = w[WEIGHT_W-1:0];
      taps[n].last = (x + 1 == hi);
      taps[n].empty = 1'b0;
      n++;
    end
    taps[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_taps.push_back(taps[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checker
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (stall_phase_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_phase_left <= $urandom_range(50, 400);
    end else begin
      stall_phase_left <= stall_phase_left - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: begin
        // long runs of stall and release
        if (stall_run == 0) begin
          out_stall_i <= ~out_stall_i;
          stall_run <= $urandom_range(1, 20);
        end else begin
          stall_run <= stall_run - 1;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (expected_taps.size() == 0) begin
        $error("unexpected result: tap_position %0d tap_weight %0d",
               tap_position_o, tap_weight_o);
        fail_count++;
      end else begin
        observed_tap = expected_taps.pop_front();
        if (tap_position_o !== observed_tap.pos) begin
          $error("tap_position mismatch: expected %0d, actual %0d",
                 observed_tap.pos, tap_position_o);
          fail_count++;
        end
        if (tap_weight_o !== observed_tap.weight) begin
          $error("tap_weight mismatch: expected %0d, actual %0d",
                 observed_tap.weight, tap_weight_o);
          fail_count++;
        end
        if (last_tap_o !== observed_tap.last) begin
          $error("last_tap mismatch: expected %0d, actual %0d",
                 observed_tap.last, last_tap_o);
          fail_count++;
        end
        if (window_empty_o !== observed_tap.empty) begin
          $error("window_empty mismatch: expected %0d, actual %0d",
                 observed_tap.empty, window_empty_o);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Called right after a rising edge; returns at the edge that took the request.
  task automatic send_center(input logic [CENTER_W-1:0] center);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    sample_center_i <= center;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_taps(center);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_taps.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [MODE_W-1:0] mode,
                           input logic signed [COEFF_W-1:0] coeff,
                           input logic [SCALE_W-1:0] scale,
                           input logic [BORDER_W-1:0] border);
    write_reg(CFG_FILTER_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_CUBIC_COEFF, {1'b0, coeff});
    write_reg(CFG_SCALE_FACTOR, CFG_DATA_W'(scale));
    write_reg(CFG_BORDER_SIZE, CFG_DATA_W'(border));
    cfg_we_i <= 1'b0;
    cfg_mode = mode;
    cfg_coeff = coeff;
    cfg_scale = scale;
    cfg_border = border;
  endtask

  function automatic logic [CENTER_W-1:0] pick_center();
    int unsigned span;
    int unsigned frac;
    span = (cfg_border > PIXEL_SPAN) ? PIXEL_SPAN : cfg_border;
    case ($urandom_range(0, 9))
      0, 1: return CENTER_W'($urandom());
      2, 3, 4: begin
        // pixel edges, pixel centers and one step off them
        case ($urandom_range(0, 3))
          0: frac = 0;
          1: frac = HALF_PIXEL;
          2: frac = 1;
          default: frac = PIXEL - 1;
        endcase
        return CENTER_W'(($urandom_range(0, span + 2) << FRAC_BITS) + frac);
      end
      default: return CENTER_W'($urandom_range(0, (span + 2) << FRAC_BITS));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_reset_defaults();
    gap_max = 4;
    send_center('0);
    send_center(CENTER_W'(HALF_PIXEL));
    send_center(CENTER_W'((100 << FRAC_BITS) | 77));
    send_center('1);
    drain();
  endtask

  task automatic test_filter_modes();
    logic [MODE_W-1:0] modes[4];
    modes = '{MODE_NEAREST, MODE_TRIANGLE, MODE_BICUBIC, MODE_UNDEFINED};
    foreach (modes[i]) begin
      configure(modes[i], -13'sd2048, 14'd4096, 14'd8192);
      send_center(CENTER_W'((4 << FRAC_BITS) + 1));
      send_center(CENTER_W'((4 << FRAC_BITS) + HALF_PIXEL));
      send_center(CENTER_W'(8 << FRAC_BITS));
      drain();
    end
  endtask

  task automatic test_edge_settings();
    // border of zero: nothing survives the clip
    configure(MODE_TRIANGLE, -13'sd2048, 14'd4096, 14'd0);
    send_center(CENTER_W'(1000));
    drain();
    // one-pixel line, strongest negative a, largest scale
    configure(MODE_BICUBIC, -13'sd4096, 14'h3FFF, 14'd1);
    send_center('0);
    send_center(CENTER_W'(300));
    send_center('1);
    drain();
    // largest positive a, border above the coordinate range
    configure(MODE_BICUBIC, 13'sd4095, 14'h3FFF, 14'h3FFF);
    send_center('1);
    send_center(CENTER_W'((5 << FRAC_BITS) + 3));
    drain();
    // zero scale
    configure(MODE_TRIANGLE, 13'sd0, 14'd0, 14'd8192);
    send_center(CENTER_W'(700));
    drain();
    configure(MODE_NEAREST, -13'sd4096, 14'h3FFF, 14'h3FFF);
    send_center(CENTER_W'((5 << FRAC_BITS) + HALF_PIXEL));
    send_center(CENTER_W'(1));
    drain();
  endtask

  task automatic test_random_settings();
    logic [MODE_W-1:0]         mode;
    logic signed [COEFF_W-1:0] coeff;
    logic [SCALE_W-1:0]        scale;
    logic [BORDER_W-1:0]       border;
    int                        neg;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0, 7:    mode = MODE_NEAREST;
        1, 4:    mode = MODE_TRIANGLE;
        5:       mode = MODE_UNDEFINED;
        default: mode = MODE_BICUBIC;
      endcase
      neg = $urandom_range(0, 4096);
      case (phase)
        2: coeff = -13'sd4096;
        3: coeff = 13'sd0;
        default: coeff = ($urandom_range(0, 4) == 0) ? COEFF_W'($urandom())
                                                     : COEFF_W'(-neg);
      endcase
      case ($urandom_range(0, 4))
        0: scale = 14'h3FFF;
        1: scale = 14'd4096;
        default: scale = SCALE_W'($urandom_range(1024, 8192));
      endcase
      if (phase == 6) scale = SCALE_W'($urandom());
      case ($urandom_range(0, 9))
        0, 1, 2: border = 14'd8192;
        3:       border = 14'h3FFF;
        4, 5:    border = BORDER_W'($urandom());
        default: border = BORDER_W'($urandom_range(1, 64));
      endcase
      case (phase % 4)
        0: gap_max = 0;
        1: gap_max = 3;
        2: gap_max = 12;
        default: gap_max = 30;
      endcase
      configure(mode, coeff, scale, border);
      for (int i = 0; i < PHASE_ITEMS; i++) send_center(pick_center());
      drain();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_filter_modes();
    test_edge_settings();
    test_random_settings();
    repeat (END_WAIT) @(posedge clk_i);
    if (fail_count == 0 && expected_taps.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
